@@ design/qkvlp_pkg.sv @@
// Package for the quoted key/value line parser.
// Holds the parse phase, status and item kind codes and the state and result structs.
// No dependencies.
package qkvlp_pkg;

    localparam logic [7:0] CHAR_NUL       = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_CR        = 8'd13;
    localparam logic [7:0] CHAR_HASH      = 8'h23;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_TILDE     = 8'h7E;

    typedef enum logic [2:0] {
        PH_PRE_KEY    = 3'd0,
        PH_IN_KEY     = 3'd1,
        PH_PRE_COLON  = 3'd2,
        PH_PRE_VALUE  = 3'd3,
        PH_IN_VALUE   = 3'd4,
        PH_POST_VALUE = 3'd5,
        PH_SKIP       = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_ENTRY      = 3'd0,
        ST_BLANK      = 3'd1,
        ST_END        = 3'd2,
        ST_BAD_CHAR   = 3'd3,
        ST_BAD_ESCAPE = 3'd4,
        ST_BAD_KEY    = 3'd5,
        ST_BAD_VALUE  = 3'd6,
        ST_NO_COLON   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_EOL   = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase  phase;
        t_phase  stop_phase;
        logic    esc_pending;
        logic    key_has_char;
        logic    key_bad;
        logic    value_bad;
        t_status pending_err;
    } t_state;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] text;
        t_status    status;
        logic       ended;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:        PH_PRE_KEY,
        stop_phase:   PH_PRE_KEY,
        esc_pending:  1'b0,
        key_has_char: 1'b0,
        key_bad:      1'b0,
        value_bad:    1'b0,
        pending_err:  ST_ENTRY
    };

endpackage

@@ design/qkvlp_step.sv @@
// Per-byte parse step: next parser state and the optional result item for one byte.
// Purely combinational; depends on qkvlp_pkg.
module qkvlp_step (
    input  logic [7:0]        i_byte,
    input  qkvlp_pkg::t_state i_state,
    output qkvlp_pkg::t_state o_state,
    output qkvlp_pkg::t_result o_result
);

    logic            is_blank;
    logic            key_ok;
    logic            printable;
    qkvlp_pkg::t_phase eff_phase;
    qkvlp_pkg::t_status eol_status;

    assign is_blank  = (i_byte == qkvlp_pkg::CHAR_SPACE) ||
                       ((i_byte >= qkvlp_pkg::CHAR_TAB) && (i_byte <= qkvlp_pkg::CHAR_CR));
    assign key_ok    = ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) ||
                       ((i_byte >= 8'h61) && (i_byte <= 8'h7A)) ||
                       ((i_byte >= 8'h30) && (i_byte <= 8'h39)) ||
                       (i_byte == qkvlp_pkg::CHAR_UNDERSCORE);
    assign printable = (i_byte >= qkvlp_pkg::CHAR_SPACE) && (i_byte <= qkvlp_pkg::CHAR_TILDE);
    assign eff_phase = (i_state.phase == qkvlp_pkg::PH_SKIP) ? i_state.stop_phase
                                                              : i_state.phase;

    always_comb begin
        eol_status = qkvlp_pkg::ST_BLANK;
        case (eff_phase)
            qkvlp_pkg::PH_PRE_KEY: begin
                eol_status = (i_byte == qkvlp_pkg::CHAR_NUL) ? qkvlp_pkg::ST_END
                                                            : qkvlp_pkg::ST_BLANK;
            end
            qkvlp_pkg::PH_IN_KEY:    eol_status = qkvlp_pkg::ST_BAD_KEY;
            qkvlp_pkg::PH_PRE_COLON: eol_status = qkvlp_pkg::ST_NO_COLON;
            qkvlp_pkg::PH_PRE_VALUE: eol_status = qkvlp_pkg::ST_BAD_VALUE;
            qkvlp_pkg::PH_IN_VALUE:  eol_status = qkvlp_pkg::ST_BAD_VALUE;
            qkvlp_pkg::PH_POST_VALUE: begin
                if (!i_state.key_has_char || i_state.key_bad) begin
                    eol_status = qkvlp_pkg::ST_BAD_KEY;
                end else if (i_state.value_bad) begin
                    eol_status = qkvlp_pkg::ST_BAD_VALUE;
                end else begin
                    eol_status = qkvlp_pkg::ST_ENTRY;
                end
            end
            default: eol_status = qkvlp_pkg::ST_BLANK;
        endcase
        if (i_state.pending_err != qkvlp_pkg::ST_ENTRY) begin
            eol_status = i_state.pending_err;
        end
    end

    always_comb begin
        o_state         = i_state;
        o_result.valid  = 1'b0;
        o_result.kind   = qkvlp_pkg::KIND_KEY;
        o_result.text   = i_byte;
        o_result.status = qkvlp_pkg::ST_ENTRY;
        o_result.ended  = 1'b0;

        if ((i_byte == qkvlp_pkg::CHAR_NUL) || (i_byte == qkvlp_pkg::CHAR_NEWLINE)) begin
            o_state         = qkvlp_pkg::STATE_RESET;
            o_result.valid  = 1'b1;
            o_result.kind   = qkvlp_pkg::KIND_EOL;
            o_result.text   = 8'd0;
            o_result.status = eol_status;
            o_result.ended  = (i_byte == qkvlp_pkg::CHAR_NUL);
        end else begin
            case (i_state.phase)
                qkvlp_pkg::PH_PRE_KEY, qkvlp_pkg::PH_PRE_COLON,
                qkvlp_pkg::PH_PRE_VALUE, qkvlp_pkg::PH_POST_VALUE: begin
                    if (is_blank) begin
                        o_state = i_state;
                    end else if (i_byte == qkvlp_pkg::CHAR_HASH) begin
                        o_state.pending_err = qkvlp_pkg::ST_ENTRY;
                        o_state.stop_phase  = i_state.phase;
                        o_state.phase       = qkvlp_pkg::PH_SKIP;
                    end else if ((i_byte == qkvlp_pkg::CHAR_COLON) &&
                                 (i_state.phase == qkvlp_pkg::PH_PRE_COLON)) begin
                        o_state.phase = qkvlp_pkg::PH_PRE_VALUE;
                    end else if ((i_byte == qkvlp_pkg::CHAR_QUOTE) &&
                                 (i_state.phase == qkvlp_pkg::PH_PRE_KEY)) begin
                        o_state.phase = qkvlp_pkg::PH_IN_KEY;
                    end else if ((i_byte == qkvlp_pkg::CHAR_QUOTE) &&
                                 (i_state.phase == qkvlp_pkg::PH_PRE_VALUE)) begin
                        o_state.phase = qkvlp_pkg::PH_IN_VALUE;
                    end else begin
                        o_state.pending_err = qkvlp_pkg::ST_BAD_CHAR;
                        o_state.stop_phase  = i_state.phase;
                        o_state.phase       = qkvlp_pkg::PH_SKIP;
                    end
                end
                qkvlp_pkg::PH_IN_KEY, qkvlp_pkg::PH_IN_VALUE: begin
                    if (!i_state.esc_pending && (i_byte == qkvlp_pkg::CHAR_QUOTE)) begin
                        o_state.phase = (i_state.phase == qkvlp_pkg::PH_IN_KEY)
                                        ? qkvlp_pkg::PH_PRE_COLON
                                        : qkvlp_pkg::PH_POST_VALUE;
                    end else if (!i_state.esc_pending &&
                                 (i_byte == qkvlp_pkg::CHAR_BACKSLASH)) begin
                        o_state.esc_pending = 1'b1;
                    end else if (i_state.esc_pending &&
                                 (i_byte != qkvlp_pkg::CHAR_QUOTE) &&
                                 (i_byte != qkvlp_pkg::CHAR_BACKSLASH)) begin
                        o_state.esc_pending = 1'b0;
                        o_state.pending_err = qkvlp_pkg::ST_BAD_ESCAPE;
                        o_state.stop_phase  = i_state.phase;
                        o_state.phase       = qkvlp_pkg::PH_SKIP;
                    end else begin
                        o_state.esc_pending = 1'b0;
                        o_result.valid      = 1'b1;
                        if (i_state.phase == qkvlp_pkg::PH_IN_KEY) begin
                            o_result.kind        = qkvlp_pkg::KIND_KEY;
                            o_state.key_has_char = 1'b1;
                            o_state.key_bad      = i_state.key_bad | ~key_ok;
                        end else begin
                            o_result.kind     = qkvlp_pkg::KIND_VALUE;
                            o_state.value_bad = i_state.value_bad | ~printable;
                        end
                    end
                end
                default: o_state = i_state;
            endcase
        end
    end

endmodule

@@ design/quoted_key_value_line_parser.sv @@
// Quoted key/value line parser. An accepted byte waits in the input register; its result
// item, if any, is captured in the result register when the byte advances. Throughput: one
// byte per cycle through the combinational parse step between the input register and the
// result register; a stalled output holds back the input stage. Reset (synchronous, active
// low) empties both registers and returns the parser to the start of a line. Depends on qkvlp_pkg and qkvlp_step.
module quoted_key_value_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_item_kind,
    output logic [7:0] o_text_byte,
    output logic [2:0] o_line_status,
    output logic       o_input_ended
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    qkvlp_pkg::t_state  r_state;
    qkvlp_pkg::t_state  n_state;
    qkvlp_pkg::t_result n_result;
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [7:0]         r_text;
    logic [2:0]         r_status;
    logic               r_ended;
    logic               advance;

    qkvlp_step u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= qkvlp_pkg::STATE_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_result.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_char_byte;
        end
        if (advance && n_result.valid) begin
            r_kind   <= 2'(n_result.kind);
            r_text   <= n_result.text;
            r_status <= 3'(n_result.status);
            r_ended  <= n_result.ended;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_kind;
    assign o_text_byte   = r_text;
    assign o_line_status = r_status;
    assign o_input_ended = r_ended;

endmodule

@@ sim/tb_quoted_key_value_line_parser.sv @@
// Testbench for quoted_key_value_line_parser: directed lines, then random entry lines,
// broken lines and noise, with random idling on both handshakes and a scoreboard check.
// Depends on qkvlp_pkg and the design sources.
module tb_quoted_key_value_line_parser;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 600;

    typedef struct {
        qkvlp_pkg::t_kind   kind;
        logic [7:0]         text;
        qkvlp_pkg::t_status status;
        logic               ended;
    } t_parsed_item;

    class t_line_parse_scoreboard;
        qkvlp_pkg::t_state st;
        t_parsed_item      expected_items[$];
        int                error_count;

        function new();
            st = qkvlp_pkg::STATE_RESET;
            error_count = 0;
        endfunction

        function qkvlp_pkg::t_status line_end_status(bit at_end);
            qkvlp_pkg::t_phase ph;
            if (st.pending_err != qkvlp_pkg::ST_ENTRY) return st.pending_err;
            ph = (st.phase == qkvlp_pkg::PH_SKIP) ? st.stop_phase : st.phase;
            case (ph)
                qkvlp_pkg::PH_PRE_KEY: begin
                    if (at_end) return qkvlp_pkg::ST_END;
                    return qkvlp_pkg::ST_BLANK;
                end
                qkvlp_pkg::PH_IN_KEY:    return qkvlp_pkg::ST_BAD_KEY;
                qkvlp_pkg::PH_PRE_COLON: return qkvlp_pkg::ST_NO_COLON;
                qkvlp_pkg::PH_PRE_VALUE, qkvlp_pkg::PH_IN_VALUE: return qkvlp_pkg::ST_BAD_VALUE;
                qkvlp_pkg::PH_POST_VALUE: begin
                    if (!st.key_has_char || st.key_bad) return qkvlp_pkg::ST_BAD_KEY;
                    if (st.value_bad) return qkvlp_pkg::ST_BAD_VALUE;
                    return qkvlp_pkg::ST_ENTRY;
                end
                default: return qkvlp_pkg::ST_BLANK;
            endcase
        endfunction

        function void stop_line(qkvlp_pkg::t_status err);
            st.pending_err = err;
            st.stop_phase = st.phase;
            st.phase = qkvlp_pkg::PH_SKIP;
        endfunction

        function void push_char(logic [7:0] c);
            t_parsed_item it;
            if (st.phase == qkvlp_pkg::PH_IN_KEY) begin
                st.key_has_char = 1'b1;
                if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                      (c >= "0" && c <= "9") || c == qkvlp_pkg::CHAR_UNDERSCORE))
                    st.key_bad = 1'b1;
                it.kind = qkvlp_pkg::KIND_KEY;
            end else begin
                if (c < qkvlp_pkg::CHAR_SPACE || c > qkvlp_pkg::CHAR_TILDE) st.value_bad = 1'b1;
                it.kind = qkvlp_pkg::KIND_VALUE;
            end
            it.text = c;
            it.status = qkvlp_pkg::ST_ENTRY;
            it.ended = 1'b0;
            expected_items.push_back(it);
        endfunction

        function void note_byte(logic [7:0] c);
            t_parsed_item it;
            bit           is_ws;
            is_ws = (c == qkvlp_pkg::CHAR_SPACE) ||
                    (c >= qkvlp_pkg::CHAR_TAB && c <= qkvlp_pkg::CHAR_CR);
            if (c == qkvlp_pkg::CHAR_NUL || c == qkvlp_pkg::CHAR_NEWLINE) begin
                it.kind = qkvlp_pkg::KIND_EOL;
                it.text = 8'd0;
                it.status = line_end_status(c == qkvlp_pkg::CHAR_NUL);
                it.ended = (c == qkvlp_pkg::CHAR_NUL);
                expected_items.push_back(it);
                st = qkvlp_pkg::STATE_RESET;
                return;
            end
            case (st.phase)
                qkvlp_pkg::PH_PRE_KEY, qkvlp_pkg::PH_PRE_COLON,
                qkvlp_pkg::PH_PRE_VALUE, qkvlp_pkg::PH_POST_VALUE: begin
                    if (!is_ws) begin
                        if (c == qkvlp_pkg::CHAR_HASH) begin
                            stop_line(qkvlp_pkg::ST_ENTRY);
                        end else if (c == qkvlp_pkg::CHAR_COLON &&
                                     st.phase == qkvlp_pkg::PH_PRE_COLON) begin
                            st.phase = qkvlp_pkg::PH_PRE_VALUE;
                        end else if (c == qkvlp_pkg::CHAR_QUOTE &&
                                     st.phase == qkvlp_pkg::PH_PRE_KEY) begin
                            st.phase = qkvlp_pkg::PH_IN_KEY;
                        end else if (c == qkvlp_pkg::CHAR_QUOTE &&
                                     st.phase == qkvlp_pkg::PH_PRE_VALUE) begin
                            st.phase = qkvlp_pkg::PH_IN_VALUE;
                        end else begin
                            stop_line(qkvlp_pkg::ST_BAD_CHAR);
                        end
                    end
                end
                qkvlp_pkg::PH_IN_KEY, qkvlp_pkg::PH_IN_VALUE: begin
                    if (st.esc_pending) begin
                        st.esc_pending = 1'b0;
                        if (c == qkvlp_pkg::CHAR_QUOTE || c == qkvlp_pkg::CHAR_BACKSLASH)
                            push_char(c);
                        else stop_line(qkvlp_pkg::ST_BAD_ESCAPE);
                    end else if (c == qkvlp_pkg::CHAR_QUOTE) begin
                        if (st.phase == qkvlp_pkg::PH_IN_KEY) st.phase = qkvlp_pkg::PH_PRE_COLON;
                        else st.phase = qkvlp_pkg::PH_POST_VALUE;
                    end else if (c == qkvlp_pkg::CHAR_BACKSLASH) begin
                        st.esc_pending = 1'b1;
                    end else begin
                        push_char(c);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_item(qkvlp_pkg::t_kind kind, logic [7:0] text,
                                 qkvlp_pkg::t_status status, logic ended);
            t_parsed_item want;
            if (expected_items.size() == 0) begin
                $display("%0t: unexpected item, kind %0d text %0h status %0d ended %0d",
                         $time, kind, text, status, ended);
                error_count++;
                return;
            end
            want = expected_items.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: item kind expected %0d, actual %0d", $time, want.kind, kind);
                error_count++;
            end
            if (text !== want.text) begin
                $display("%0t: text byte expected %0h, actual %0h", $time, want.text, text);
                error_count++;
            end
            if (status !== want.status) begin
                $display("%0t: line status expected %0d, actual %0d",
                         $time, want.status, status);
                error_count++;
            end
            if (ended !== want.ended) begin
                $display("%0t: input ended expected %0d, actual %0d",
                         $time, want.ended, ended);
                error_count++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_byte = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_item_kind;
    logic [7:0] o_text_byte;
    logic [2:0] o_line_status;
    logic       o_input_ended;

    t_line_parse_scoreboard sb;
    logic [7:0] line_bytes[$];
    string      key_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
    bit         in_idle_on = 1'b1;
    bit         drain_mode = 1'b0;
    int         stall_left = 0;
    int         stall_pick;
    int         cycle_count = 0;
    int         random_bytes = 0;
    int         line_pick;
    int         cut;

    quoted_key_value_line_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_byte   (i_char_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_item_kind   (o_item_kind),
        .o_text_byte   (o_text_byte),
        .o_line_status (o_line_status),
        .o_input_ended (o_input_ended)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_item(qkvlp_pkg::t_kind'(o_item_kind), o_text_byte,
                          qkvlp_pkg::t_status'(o_line_status), o_input_ended);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else begin
            if ($urandom_range(0, 63) == 0) drain_mode = !drain_mode;
            stall_pick = $urandom_range(0, 99);
            if (drain_mode || stall_pick < 65) begin
                i_out_ready <= 1'b1;
            end else if (stall_pick < 95) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(8, 30);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        int pick;
        gap = 0;
        if (in_idle_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90) gap = $urandom_range(5, 20);
            else if (pick >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] text_noise_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == qkvlp_pkg::CHAR_NEWLINE);
        return c;
    endfunction

    function automatic void add_ws();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
                0: line_bytes.push_back(qkvlp_pkg::CHAR_TAB);
                1: line_bytes.push_back(8'd11);
                2: line_bytes.push_back(8'd12);
                3: line_bytes.push_back(qkvlp_pkg::CHAR_CR);
                default: line_bytes.push_back(qkvlp_pkg::CHAR_SPACE);
            endcase
        end
    endfunction

    function automatic void add_body(bit is_key);
        int         n;
        int         r;
        logic [7:0] c;
        n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                line_bytes.push_back(qkvlp_pkg::CHAR_BACKSLASH);
                line_bytes.push_back(r[0] ? qkvlp_pkg::CHAR_QUOTE : qkvlp_pkg::CHAR_BACKSLASH);
            end else if (r < 12) begin
                do c = text_noise_byte();
                while (c == qkvlp_pkg::CHAR_QUOTE || c == qkvlp_pkg::CHAR_BACKSLASH);
                line_bytes.push_back(c);
            end else if (is_key) begin
                line_bytes.push_back(key_chars[$urandom_range(0, key_chars.len() - 1)]);
            end else begin
                do c = 8'($urandom_range(32, 126));
                while (c == qkvlp_pkg::CHAR_QUOTE || c == qkvlp_pkg::CHAR_BACKSLASH);
                line_bytes.push_back(c);
            end
        end
    endfunction

    function automatic void add_entry();
        add_ws();
        line_bytes.push_back(qkvlp_pkg::CHAR_QUOTE);
        add_body(1'b1);
        line_bytes.push_back(qkvlp_pkg::CHAR_QUOTE);
        add_ws();
        line_bytes.push_back(qkvlp_pkg::CHAR_COLON);
        add_ws();
        line_bytes.push_back(qkvlp_pkg::CHAR_QUOTE);
        add_body(1'b0);
        line_bytes.push_back(qkvlp_pkg::CHAR_QUOTE);
        add_ws();
        if ($urandom_range(0, 7) == 0) begin
            line_bytes.push_back(qkvlp_pkg::CHAR_HASH);
            repeat ($urandom_range(0, 4)) line_bytes.push_back(text_noise_byte());
        end
    endfunction

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(qkvlp_pkg::CHAR_NUL);
        send_text("\"\\\"\":\"~\"\n");
        send_text("\"a\\q\n");
        send_byte(8'hFF);
        send_byte(qkvlp_pkg::CHAR_NEWLINE);
        send_text(" #");
        send_byte(qkvlp_pkg::CHAR_NUL);
        send_text("\"k\"\n");

        while (random_bytes < RANDOM_BYTES) begin
            line_bytes.delete();
            in_idle_on = ($urandom_range(0, 3) != 0);
            line_pick = $urandom_range(0, 99);
            if (line_pick < 70) begin
                add_entry();
            end else if (line_pick < 88) begin
                add_entry();
                cut = $urandom_range(0, line_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0: while (line_bytes.size() > cut) void'(line_bytes.pop_back());
                    1: line_bytes.insert(cut, text_noise_byte());
                    default: begin
                        line_bytes.insert(cut, text_noise_byte());
                        line_bytes.insert(cut, qkvlp_pkg::CHAR_BACKSLASH);
                    end
                endcase
            end else begin
                repeat ($urandom_range(0, 8)) line_bytes.push_back(text_noise_byte());
            end
            line_bytes.push_back(($urandom_range(0, 11) == 0) ? qkvlp_pkg::CHAR_NUL
                                                               : qkvlp_pkg::CHAR_NEWLINE);
            random_bytes += line_bytes.size();
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
        end

        i_in_valid <= 1'b0;
        while (sb.expected_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.error_count == 0 && sb.expected_items.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
